>>> design/bps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bps_pkg;

  // Field and register widths.
  localparam int TICK_W      = 16;
  localparam int PATTERN_W   = 3;
  localparam int BEEP_W      = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Item kinds carried by req_type.
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_TRIGGER = 1'b1;

  // Pattern codes.
  localparam logic [PATTERN_W-1:0] PAT_OFF   = 3'd0;
  localparam logic [PATTERN_W-1:0] PAT_FRONT = 3'd1;
  localparam logic [PATTERN_W-1:0] PAT_LEFT  = 3'd2;
  localparam logic [PATTERN_W-1:0] PAT_RIGHT = 3'd3;
  localparam logic [PATTERN_W-1:0] PAT_FALL  = 3'd4;

  // Short beeps per round for each short pattern.
  localparam logic [BEEP_W-1:0] BEEPS_FRONT = 2'd3;
  localparam logic [BEEP_W-1:0] BEEPS_LEFT  = 2'd2;
  localparam logic [BEEP_W-1:0] BEEPS_RIGHT = 2'd1;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_ON  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_GAP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_ON   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUND_GAP = 2'd3;

  // Register reset values.
  localparam logic [TICK_W-1:0] SHORT_ON_RESET  = 16'd150;
  localparam logic [TICK_W-1:0] SHORT_GAP_RESET = 16'd80;
  localparam logic [TICK_W-1:0] LONG_ON_RESET   = 16'd1500;
  localparam logic [TICK_W-1:0] ROUND_GAP_RESET = 16'd600;

  // Phase counter saturation value.
  localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

  // Timing registers as seen by the sequencer.
  typedef struct packed {
    logic [TICK_W-1:0] short_on_ticks;
    logic [TICK_W-1:0] short_gap_ticks;
    logic [TICK_W-1:0] long_on_ticks;
    logic [TICK_W-1:0] round_gap_ticks;
  } cfg_t;

  // Sequencer state.
  typedef struct packed {
    logic [PATTERN_W-1:0] current_pattern;
    logic                 active_flag;
    logic                 in_on_phase;
    logic [BEEP_W-1:0]    beep_count;
    logic                 in_round_gap;
    logic [TICK_W-1:0]    phase_ticks;
    logic                 drive_level;
  } seq_state_t;

endpackage
`default_nettype wire

>>> design/beep_pattern_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Beep pattern sequencer. Each input item is a millisecond tick (req_type 0)
// or a pattern trigger (req_type 1), and each item gives exactly one result
// item with the buzzer level (sounding) and the sequence activity (running)
// after it. An accepted item is held in an input register, the sequence
// state is advanced by one short pass of compare and increment logic, and
// the result lands in an output register once that register is free or
// being emptied. One item is taken every cycle while results are taken.
// A stalled result holds the item in the input register, and the input
// side takes a new item again as soon as that register can move on.
// Timing registers are written through cfg_we, cfg_index and cfg_data,
// which the user must do only while no item is in flight; nothing checks it.
module beep_pattern_sequencer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic                           req_type,
  input  wire logic [bps_pkg::PATTERN_W-1:0]   pattern,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic                           sounding,
  output      logic                           running
);

  bps_pkg::cfg_t       cfg;
  bps_pkg::seq_state_t state;
  bps_pkg::seq_state_t state_next;

  logic                         stage_valid;
  logic                         stage_req_type;
  logic [bps_pkg::PATTERN_W-1:0] stage_pattern;
  logic                         advance;

  bps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bps_step u_step (
    .req_type   (stage_req_type),
    .pattern    (stage_pattern),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next)
  );

  // The held item moves on when the output register is free or being emptied.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_req_type <= req_type;
      stage_pattern  <= pattern;
    end
  end

  // Sequence state, updated once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.current_pattern <= bps_pkg::PAT_OFF;
      state.active_flag     <= 1'b0;
      state.in_on_phase     <= 1'b1;
      state.beep_count      <= '0;
      state.in_round_gap    <= 1'b0;
      state.phase_ticks     <= '0;
      state.drive_level     <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sounding <= state_next.drive_level;
      running  <= state_next.active_flag;
    end
  end

endmodule
`default_nettype wire

>>> design/bps_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module bps_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bps_pkg::cfg_t                       cfg
);

  // Timing registers, written one at a time through the plain write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_on_ticks  <= bps_pkg::SHORT_ON_RESET;
      cfg.short_gap_ticks <= bps_pkg::SHORT_GAP_RESET;
      cfg.long_on_ticks   <= bps_pkg::LONG_ON_RESET;
      cfg.round_gap_ticks <= bps_pkg::ROUND_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bps_pkg::REG_SHORT_ON:  cfg.short_on_ticks  <= cfg_data;
        bps_pkg::REG_SHORT_GAP: cfg.short_gap_ticks <= cfg_data;
        bps_pkg::REG_LONG_ON:   cfg.long_on_ticks   <= cfg_data;
        bps_pkg::REG_ROUND_GAP: cfg.round_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/bps_step.sv
`timescale 1ns / 1ps
`default_nettype none
module bps_step (
  input  wire logic                         req_type,
  input  wire logic [bps_pkg::PATTERN_W-1:0] pattern,
  input  wire bps_pkg::cfg_t                cfg,
  input  wire bps_pkg::seq_state_t          state,
  output bps_pkg::seq_state_t               state_next
);

  logic [bps_pkg::TICK_W-1:0] ticks_inc;
  logic [bps_pkg::BEEP_W-1:0] total;

  // Saturating phase count for this tick.
  assign ticks_inc = (state.phase_ticks == bps_pkg::TICK_MAX) ?
                     state.phase_ticks : state.phase_ticks + 1'b1;

  // Number of short beeps in one round of the current pattern.
  always_comb begin
    case (state.current_pattern)
      bps_pkg::PAT_FRONT: total = bps_pkg::BEEPS_FRONT;
      bps_pkg::PAT_LEFT:  total = bps_pkg::BEEPS_LEFT;
      default:            total = bps_pkg::BEEPS_RIGHT;
    endcase
  end

  // One item: a trigger, or a tick while a pattern runs, may advance the sequence state.
  always_comb begin
    state_next = state;
    if (req_type == bps_pkg::REQ_TRIGGER) begin
      if (pattern == bps_pkg::PAT_OFF) begin
        state_next.active_flag     = 1'b0;
        state_next.current_pattern = bps_pkg::PAT_OFF;
        state_next.drive_level     = 1'b0;
      end else if (pattern <= bps_pkg::PAT_FALL &&
                   !(pattern == state.current_pattern && state.active_flag)) begin
        // A new pattern restarts the round; the drive level waits for a tick.
        state_next.current_pattern = pattern;
        state_next.active_flag     = 1'b1;
        state_next.beep_count      = '0;
        state_next.in_on_phase     = 1'b1;
        state_next.in_round_gap    = 1'b0;
        state_next.phase_ticks     = '0;
      end
    end else if (state.active_flag) begin
      state_next.phase_ticks = ticks_inc;
      if (state.in_round_gap) begin
        state_next.drive_level = 1'b0;
        if (ticks_inc >= cfg.round_gap_ticks) begin
          state_next.beep_count   = '0;
          state_next.in_on_phase  = 1'b1;
          state_next.in_round_gap = 1'b0;
          state_next.phase_ticks  = '0;
        end
      end else if (state.current_pattern == bps_pkg::PAT_FALL) begin
        state_next.drive_level = 1'b1;
        if (ticks_inc >= cfg.long_on_ticks) begin
          state_next.drive_level  = 1'b0;
          state_next.in_round_gap = 1'b1;
          state_next.phase_ticks  = '0;
        end
      end else if (state.beep_count >= total) begin
        // Last short beep done: enter the round gap.
        state_next.drive_level  = 1'b0;
        state_next.in_round_gap = 1'b1;
        state_next.phase_ticks  = '0;
      end else if (state.in_on_phase) begin
        state_next.drive_level = 1'b1;
        if (ticks_inc >= cfg.short_on_ticks) begin
          state_next.in_on_phase = 1'b0;
          state_next.phase_ticks = '0;
        end
      end else begin
        state_next.drive_level = 1'b0;
        if (ticks_inc >= cfg.short_gap_ticks) begin
          state_next.beep_count  = state.beep_count + 1'b1;
          state_next.in_on_phase = 1'b1;
          state_next.phase_ticks = '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/bps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bps_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic sounding,
  input wire logic running
);

  // The buzzer is never driven while no pattern runs.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !running |-> !sounding)
    else $error("buzzer sounding while no pattern is running");

  // The input side stalls only behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the output side is free");

  // Reset empties the block and opens the input.
  assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // A stalled result item holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sounding) && $stable(running))
    else $error("stalled result item changed or dropped");

endmodule

bind beep_pattern_sequencer_unit bps_checker u_bps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sounding  (sounding),
  .running   (running)
);
`default_nettype wire

>>> test/beep_pattern_sequencer_unit_tb.sv
`timescale 1ns / 1ps
module beep_pattern_sequencer_unit_tb;

  typedef logic [bps_pkg::PATTERN_W-1:0]   pat_t;
  typedef logic [bps_pkg::CFG_DATA_W-1:0]  ticks_t;
  typedef logic [bps_pkg::CFG_INDEX_W-1:0] idx_t;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int SEGMENT_ITEMS  = 30;
  localparam int SEGMENTS       = 4;
  localparam int PRINT_LIMIT    = 20;
  localparam int FIRST_UNUSED_PAT = int'(bps_pkg::PAT_FALL) + 1;
  localparam int LAST_UNUSED_PAT  = (1 << bps_pkg::PATTERN_W) - 1;

  // Tracks the sequencer state and the buzzer levels expected back.
  class buzzer_predictor;
    logic [bps_pkg::TICK_W-1:0]    short_on, short_gap, long_on, round_gap;
    logic [bps_pkg::PATTERN_W-1:0] pat_now;
    logic                          seq_active, on_phase, in_gap, buzz_on;
    logic [bps_pkg::BEEP_W-1:0]    beeps_done;
    logic [bps_pkg::TICK_W-1:0]    ticks;
    logic [1:0]                    expected_levels[$];
    int                            mismatches;
    int                            checked;

    function new();
      short_on   = bps_pkg::SHORT_ON_RESET;
      short_gap  = bps_pkg::SHORT_GAP_RESET;
      long_on    = bps_pkg::LONG_ON_RESET;
      round_gap  = bps_pkg::ROUND_GAP_RESET;
      pat_now    = bps_pkg::PAT_OFF;
      seq_active = 1'b0;
      on_phase   = 1'b1;
      beeps_done = '0;
      in_gap     = 1'b0;
      ticks      = '0;
      buzz_on    = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(idx_t idx, ticks_t val);
      case (idx)
        bps_pkg::REG_SHORT_ON:  short_on  = val;
        bps_pkg::REG_SHORT_GAP: short_gap = val;
        bps_pkg::REG_LONG_ON:   long_on   = val;
        bps_pkg::REG_ROUND_GAP: round_gap = val;
        default: ;
      endcase
    endfunction

    function void restart_round();
      beeps_done = '0;
      on_phase   = 1'b1;
      in_gap     = 1'b0;
      ticks      = '0;
    endfunction

    function void open_round_gap();
      buzz_on = 1'b0;
      in_gap  = 1'b1;
      ticks   = '0;
    endfunction

    // Applies one accepted item; returns 1 when the item moved the sequence.
    function bit note_item(logic rt, pat_t pat);
      bit                         moved;
      logic [bps_pkg::BEEP_W-1:0] beeps_per_round;
      moved = 1'b0;
      if (rt == bps_pkg::REQ_TRIGGER) begin
        if (pat == bps_pkg::PAT_OFF) begin
          moved      = seq_active;
          seq_active = 1'b0;
          pat_now    = bps_pkg::PAT_OFF;
          buzz_on    = 1'b0;
        end else if (pat <= bps_pkg::PAT_FALL && !(pat == pat_now && seq_active)) begin
          // A new pattern restarts the round; the buzzer level waits for a tick.
          moved      = 1'b1;
          pat_now    = pat;
          seq_active = 1'b1;
          restart_round();
        end
      end else if (seq_active) begin
        moved = 1'b1;
        if (ticks != bps_pkg::TICK_MAX) ticks = ticks + 1'b1;
        if (in_gap) begin
          buzz_on = 1'b0;
          if (ticks >= round_gap) restart_round();
        end else if (pat_now == bps_pkg::PAT_FALL) begin
          buzz_on = 1'b1;
          if (ticks >= long_on) open_round_gap();
        end else begin
          case (pat_now)
            bps_pkg::PAT_FRONT: beeps_per_round = bps_pkg::BEEPS_FRONT;
            bps_pkg::PAT_LEFT:  beeps_per_round = bps_pkg::BEEPS_LEFT;
            default:            beeps_per_round = bps_pkg::BEEPS_RIGHT;
          endcase
          if (beeps_done >= beeps_per_round) begin
            open_round_gap();
          end else if (on_phase) begin
            buzz_on = 1'b1;
            if (ticks >= short_on) begin
              on_phase = 1'b0;
              ticks    = '0;
            end
          end else begin
            buzz_on = 1'b0;
            if (ticks >= short_gap) begin
              beeps_done = beeps_done + 1'b1;
              on_phase   = 1'b1;
              ticks      = '0;
            end
          end
        end
      end
      expected_levels.push_back({buzz_on, seq_active});
      return moved;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    task report(string msg);
      if (mismatches < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic snd, logic run);
      logic [1:0] want;
      if (expected_levels.size() == 0) begin
        report($sformatf("result sounding=%b running=%b with nothing expected", snd, run));
        return;
      end
      want = expected_levels.pop_front();
      if (snd !== want[1])
        report($sformatf("result %0d: sounding %b, expected %b", checked, snd, want[1]));
      if (run !== want[0])
        report($sformatf("result %0d: running %b, expected %b", checked, run, want[0]));
      checked++;
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_we = 1'b0;
  idx_t   cfg_index = '0;
  ticks_t cfg_data = '0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   req_type = bps_pkg::REQ_TICK;
  pat_t   pattern = bps_pkg::PAT_OFF;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   sounding;
  logic   running;

  buzzer_predictor predictor;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              item_count = 0;
  int              moved_count = 0;
  int              reg_writes = 0;
  int              cycle_count = 0;

  beep_pattern_sequencer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .pattern   (pattern),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sounding  (sounding),
    .running   (running)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The result side stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Results are sampled mid-cycle, where everything driven at the edge has settled.
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready)
      predictor.check_result(sounding, running);
  end

  // Hard stop in case the block hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             predictor.pending());
    $display("TB_ERROR");
    $finish;
  end

  // Offers one item, with random idle cycles first, and waits for its acceptance.
  task automatic send_item(input logic rt, input pat_t pat);
    bit accepted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      req_type <= 1'($urandom_range(1));
      pattern  <= pat_t'($urandom_range(LAST_UNUSED_PAT));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    pattern  <= pat;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = (in_ready === 1'b1);
      @(posedge clk);
    end
    if (predictor.note_item(rt, pat)) moved_count++;
    item_count++;
  endtask

  task automatic send_tick();
    send_item(bps_pkg::REQ_TICK, pat_t'($urandom_range(LAST_UNUSED_PAT)));
  endtask

  // Stops sending until every expected result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (predictor.pending() != 0);
  endtask

  // Writes all four timing registers on back-to-back cycles.
  task automatic write_config(input ticks_t short_on, short_gap, long_on, round_gap);
    ticks_t vals[4];
    vals[bps_pkg::REG_SHORT_ON]  = short_on;
    vals[bps_pkg::REG_SHORT_GAP] = short_gap;
    vals[bps_pkg::REG_LONG_ON]   = long_on;
    vals[bps_pkg::REG_ROUND_GAP] = round_gap;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_t'(i);
      cfg_data  <= vals[i];
      predictor.write_reg(idx_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    reg_writes += 4;
  endtask

  // Mostly short phases, now and then a longer one.
  function automatic ticks_t pick_ticks();
    return ($urandom_range(7) == 0) ? ticks_t'($urandom_range(40, 7)) :
                                      ticks_t'($urandom_range(6));
  endfunction

  initial begin
    int idle_send[3];
    int idle_recv[3];
    int target;
    int roll;

    idle_send = '{19, 49, 0};
    idle_recv = '{49, 19, 0};
    predictor = new();
    send_idle_pct = idle_send[0];
    recv_idle_pct = idle_recv[0];
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Idle behavior and unused codes, under the reset timing.
    send_item(bps_pkg::REQ_TICK, bps_pkg::PAT_FALL);
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_OFF);
    for (int code = FIRST_UNUSED_PAT; code <= LAST_UNUSED_PAT; code++)
      send_item(bps_pkg::REQ_TRIGGER, pat_t'(code));
    // One right beep past the end of its reset on time.
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_RIGHT);
    repeat (int'(bps_pkg::SHORT_ON_RESET) + 2) send_tick();

    // Short timing with a zero on time, which counts as one.
    wait_for_results();
    write_config('0, 16'd2, 16'd3, 16'd1);
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_FRONT);
    repeat (12) send_tick();
    // Same pattern again must not restart.
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_FRONT);
    send_tick();
    // A new pattern restarts while the buzzer keeps its level.
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_LEFT);
    repeat (3) send_tick();
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_FALL);
    repeat (5) send_tick();
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_FALL);
    send_tick();
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_OFF);
    send_tick();
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_RIGHT);
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_OFF);

    // Random part, in three idle mixes, with fresh timing per segment.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = idle_send[ph];
      recv_idle_pct = idle_recv[ph];
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        wait_for_results();
        write_config(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
        target = moved_count + SEGMENT_ITEMS;
        while (moved_count < target) begin
          roll = $urandom_range(99);
          if (roll < 91)
            send_tick();
          else if (roll < 93)
            send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_OFF);
          else if (roll < 95)
            send_item(bps_pkg::REQ_TRIGGER,
                      pat_t'($urandom_range(LAST_UNUSED_PAT, FIRST_UNUSED_PAT)));
          else
            send_item(bps_pkg::REQ_TRIGGER,
                      pat_t'($urandom_range(bps_pkg::PAT_FALL, bps_pkg::PAT_FRONT)));
        end
      end
    end

    // Full-scale on times: the fall beep keeps sounding far from its end.
    wait_for_results();
    write_config(bps_pkg::TICK_MAX, bps_pkg::TICK_MAX, bps_pkg::TICK_MAX, 16'd1);
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_FALL);
    repeat (20) send_tick();
    send_item(bps_pkg::REQ_TRIGGER, bps_pkg::PAT_OFF);

    wait_for_results();
    repeat (4) @(posedge clk);
    if (predictor.pending() != 0)
      predictor.report($sformatf("%0d results never arrived", predictor.pending()));
    $display("Run covered %0d items (%0d moved the sequence), %0d results checked.",
             item_count, moved_count, predictor.checked);
    $display("Timing registers written %0d times, from zero to full scale; %0d mismatches.",
             reg_writes, predictor.mismatches);
    if (predictor.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> beep_pattern_sequencer_unit.f
design/bps_pkg.sv
design/bps_cfg_regs.sv
design/bps_step.sv
design/beep_pattern_sequencer_unit.sv
design/bps_checker.sv
test/beep_pattern_sequencer_unit_tb.sv
